/* design/cpss_pkg.sv */
// Shared widths, constants, types and scaling functions of the servo controller.
package cpss_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 10;
    localparam int DUTY_W     = 10;
    localparam int DRV_W      = 15;
    localparam int GAIN_W     = 16;
    localparam int UPOS_W     = 9;
    localparam int USPD_W     = 7;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int SCL_W  = 20;              // unsigned scaled sample before offset
    localparam int POS_W  = 21;              // angles and setpoints, Q10.10
    localparam int SPD_W  = 17;              // measured speed, Q10.10
    localparam int ERR_W  = 25;              // speed error, Q10.10
    localparam int MA_W   = 17;              // multiplier coefficient operand
    localparam int MB_W   = 25;              // multiplier signal operand
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int T_W    = 19;              // offset drive for the duty mapping
    localparam int Z_W    = 19;
    localparam int Q_W    = 11;
    localparam int R_W    = 20;

    localparam int FRAC_SH = 10;             // Q10.10 fraction bits
    localparam int RND_SH  = 12;             // Q4.12 fraction bits
    localparam int RND_HALF = 1 << (RND_SH - 1);

    // Converter scaling: full scale is 2^SAMPLE_W - 1
    localparam int ADC_SHIFT   = SAMPLE_W;
    localparam int HALF_ADC    = ((1 << SAMPLE_W) - 1) / 2;
    localparam int ANGLE_STEP  = 360;
    localparam int SPEED_STEP  = 100;
    localparam int DEG180_Q    = 184320;
    localparam int DEG360_Q    = 368640;
    localparam int SPD50_Q     = 51200;

    // Drive limits and duty mapping
    localparam int DRIVE_MAX_Q = 13926;
    localparam int DRIVE_MIN_M = 13619;      // magnitude of the negative limit
    localparam int DUTY_VSCALE = 10;
    localparam int DUTY_OFFSET = 136192;
    localparam int DUTY_DIV    = 269;        // 275456 = 269 * 1024
    localparam int RECIP_SH    = 19;
    localparam int RECIP_M     = (1 << RECIP_SH) / DUTY_DIV;
    localparam int DUTY_MAX    = (1 << DUTY_W) - 1;

    localparam logic signed [DRV_W-1:0] DRIVE_MAX_D = DRV_W'(DRIVE_MAX_Q);
    localparam logic signed [DRV_W-1:0] DRIVE_MIN_D = -(DRV_W'(DRIVE_MIN_M));

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_USER = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_USER_POSITION = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_USER_SPEED    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_A1      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_B0      = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_B1      = CFG_IDX_W'(7);

    typedef struct packed {
        logic                      control_mode;
        logic                      setpoint_from_user;
        logic signed [UPOS_W-1:0]  user_position;
        logic signed [USPD_W-1:0]  user_speed;
        logic signed [GAIN_W-1:0]  position_gain;
        logic signed [GAIN_W-1:0]  speed_a1;
        logic signed [GAIN_W-1:0]  speed_b0;
        logic signed [GAIN_W-1:0]  speed_b1;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        control_mode:       1'b0,
        setpoint_from_user: 1'b0,
        user_position:      '0,
        user_speed:         '0,
        position_gain:      GAIN_W'(2458),
        speed_a1:           GAIN_W'(4096),
        speed_b0:           GAIN_W'(304),
        speed_b1:           GAIN_W'(270)
    };

    // Datapath operations
    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_SCALE,
        ALU_UNWRAP_LO,
        ALU_UNWRAP_HI,
        ALU_EDIFF,
        ALU_WRAP_LO,
        ALU_WRAP_HI,
        ALU_ERR_POS,
        ALU_ERR_SPD,
        ALU_DRIVE,
        ALU_DUTY_PREP,
        ALU_DUTY
    } alu_op_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_GAIN_E,
        MUL_A1_PD,
        MUL_B0_ERR,
        MUL_B1_PE,
        MUL_RECIP
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        alu_op_t  alu_op;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     capture;
        logic     commit;
    } ctl_t;

    // x / 1023 for x below 1023 * 1024: (x + (x >> 10) + 1) >> 10
    function automatic logic [SCL_W-1:0] div_adc(input logic [SCL_W-1:0] x);
        return (x + (x >> ADC_SHIFT) + SCL_W'(1)) >> ADC_SHIFT;
    endfunction

    // round(adc * 360 / 1023) - 180 degrees, Q10.10
    function automatic logic signed [POS_W-1:0] scale_angle(input logic [SAMPLE_W-1:0] a);
        logic [SCL_W-1:0]      base;
        logic [SCL_W-1:0]      sum;
        logic signed [SCL_W:0] tmp;
        base = SCL_W'(a) * SCL_W'(ANGLE_STEP);
        sum  = base + div_adc(base + SCL_W'(HALF_ADC));
        tmp  = $signed({1'b0, sum}) - (SCL_W + 1)'(DEG180_Q);
        return POS_W'(tmp);
    endfunction

    // round(adc * 100 / 1023) - 50, Q10.10
    function automatic logic signed [SPD_W-1:0] scale_speed(input logic [SAMPLE_W-1:0] a);
        logic [SCL_W-1:0]      base;
        logic [SCL_W-1:0]      sum;
        logic signed [SCL_W:0] tmp;
        base = SCL_W'(a) * SCL_W'(SPEED_STEP);
        sum  = base + div_adc(base + SCL_W'(HALF_ADC));
        tmp  = $signed({1'b0, sum}) - (SCL_W + 1)'(SPD50_Q);
        return SPD_W'(tmp);
    endfunction

endpackage

/* design/cpss_if.sv */
// Sample and result channel interfaces of the servo controller.
interface cpss_in_if;
    import cpss_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] position_sample;
    logic [SAMPLE_W-1:0] speed_sample;
    logic [SAMPLE_W-1:0] knob_sample;

    modport source (output valid, output position_sample, output speed_sample,
                    output knob_sample, input ready);
    modport sink   (input valid, input position_sample, input speed_sample,
                    input knob_sample, output ready);
endinterface

interface cpss_out_if;
    import cpss_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [DUTY_W-1:0]       pwm_duty;
    logic signed [DRV_W-1:0] drive_level;

    modport source (output valid, output pwm_duty, output drive_level, input ready);
    modport sink   (input valid, input pwm_duty, input drive_level, output ready);
endinterface

/* design/cpss_seq.sv */
// Microcode sequencer: step counter, control store and result valid flag.
module cpss_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           speed_mode,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output cpss_pkg::ctl_t ctl
);
    import cpss_pkg::*;

    localparam int STEP_W = 5;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SPEED,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        alu_op_t           alu_op;
        mul_sel_t          mul_sel;
        acc_op_t           acc_op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              last;
        logic              commit;
    } uword_t;

    localparam logic [STEP_W-1:0] ST_WAIT      = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_SCALE     = STEP_W'(1);
    localparam logic [STEP_W-1:0] ST_UNWRAP_LO = STEP_W'(2);
    localparam logic [STEP_W-1:0] ST_UNWRAP_HI = STEP_W'(3);
    localparam logic [STEP_W-1:0] ST_EDIFF     = STEP_W'(4);
    localparam logic [STEP_W-1:0] ST_WRAP_LO   = STEP_W'(5);
    localparam logic [STEP_W-1:0] ST_WRAP_HI   = STEP_W'(6);
    localparam logic [STEP_W-1:0] ST_MUL_GAIN  = STEP_W'(7);
    localparam logic [STEP_W-1:0] ST_ERR_POS   = STEP_W'(8);
    localparam logic [STEP_W-1:0] ST_ERR_SPD   = STEP_W'(9);
    localparam logic [STEP_W-1:0] ST_MUL_A1    = STEP_W'(10);
    localparam logic [STEP_W-1:0] ST_MUL_B0    = STEP_W'(11);
    localparam logic [STEP_W-1:0] ST_MUL_B1    = STEP_W'(12);
    localparam logic [STEP_W-1:0] ST_ACC_SUB   = STEP_W'(13);
    localparam logic [STEP_W-1:0] ST_DRIVE     = STEP_W'(14);
    localparam logic [STEP_W-1:0] ST_DUTY_PREP = STEP_W'(15);
    localparam logic [STEP_W-1:0] ST_MUL_RECIP = STEP_W'(16);
    localparam logic [STEP_W-1:0] ST_DUTY      = STEP_W'(17);
    localparam logic [STEP_W-1:0] ST_FINISH    = STEP_W'(18);

    localparam uword_t NOP_WORD = '{
        alu_op:  ALU_NOP,
        mul_sel: MUL_NONE,
        acc_op:  ACC_HOLD,
        cond:    COND_NONE,
        target:  ST_WAIT,
        last:    1'b0,
        commit:  1'b0
    };

    // Control store
    function automatic uword_t rom_word(input logic [STEP_W-1:0] s);
        uword_t w;
        w = NOP_WORD;
        unique case (s)
            ST_WAIT:      begin w.cond = COND_NO_INPUT; w.target = ST_WAIT; end
            ST_SCALE:
            begin
                w.alu_op = ALU_SCALE;
                w.cond   = COND_SPEED;
                w.target = ST_ERR_SPD;
            end
            ST_UNWRAP_LO: w.alu_op = ALU_UNWRAP_LO;
            ST_UNWRAP_HI: w.alu_op = ALU_UNWRAP_HI;
            ST_EDIFF:     w.alu_op = ALU_EDIFF;
            ST_WRAP_LO:   w.alu_op = ALU_WRAP_LO;
            ST_WRAP_HI:   w.alu_op = ALU_WRAP_HI;
            ST_MUL_GAIN:  w.mul_sel = MUL_GAIN_E;
            ST_ERR_POS:
            begin
                w.alu_op = ALU_ERR_POS;
                w.cond   = COND_ALWAYS;
                w.target = ST_MUL_A1;
            end
            ST_ERR_SPD:   w.alu_op = ALU_ERR_SPD;
            ST_MUL_A1:    w.mul_sel = MUL_A1_PD;
            ST_MUL_B0:    begin w.mul_sel = MUL_B0_ERR; w.acc_op = ACC_LOAD; end
            ST_MUL_B1:    begin w.mul_sel = MUL_B1_PE;  w.acc_op = ACC_ADD;  end
            ST_ACC_SUB:   w.acc_op = ACC_SUB;
            ST_DRIVE:     w.alu_op = ALU_DRIVE;
            ST_DUTY_PREP: w.alu_op = ALU_DUTY_PREP;
            ST_MUL_RECIP: w.mul_sel = MUL_RECIP;
            ST_DUTY:      w.alu_op = ALU_DUTY;
            ST_FINISH:
            begin
                w.cond   = COND_OUT_BUSY;
                w.target = ST_FINISH;
                w.last   = 1'b1;
                w.commit = 1'b1;
            end
            default:      begin w.cond = COND_ALWAYS; w.target = ST_WAIT; end
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    uword_t            uw;
    logic              in_fire;
    logic              out_free;
    logic              take;
    logic              commit;

    assign in_ready  = (step_reg == ST_WAIT);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        uw       = rom_word(step_reg);
        in_fire  = in_valid && in_ready;
        out_free = !out_valid_reg || out_ready;
        unique case (uw.cond)
            COND_NONE:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_INPUT: take = !in_fire;
            COND_SPEED:    take = speed_mode;
            COND_OUT_BUSY: take = !out_free;
            default:       take = 1'b0;
        endcase
        if (take)
        begin
            step_next = uw.target;
        end
        else if (uw.last)
        begin
            step_next = ST_WAIT;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
        commit = uw.commit && out_free;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign ctl = '{
        alu_op:  uw.alu_op,
        mul_sel: uw.mul_sel,
        acc_op:  uw.acc_op,
        capture: in_fire,
        commit:  commit
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/cpss_dp.sv */
// Datapath: scalers, shared multiplier, accumulator, ALU and loop state.
module cpss_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cpss_pkg::ctl_t                    ctl,
    input  cpss_pkg::cfg_t                    cfg,
    input  logic [cpss_pkg::SAMPLE_W-1:0]     position_sample,
    input  logic [cpss_pkg::SAMPLE_W-1:0]     speed_sample,
    input  logic [cpss_pkg::SAMPLE_W-1:0]     knob_sample,
    output logic [cpss_pkg::DUTY_W-1:0]       pwm_duty,
    output logic signed [cpss_pkg::DRV_W-1:0] drive_level
);
    import cpss_pkg::*;

    localparam logic signed [POS_W:0]   DEG180_X = (POS_W + 1)'(DEG180_Q);
    localparam logic signed [POS_W-1:0] DEG180_P = POS_W'(DEG180_Q);
    localparam logic signed [POS_W-1:0] DEG360_P = POS_W'(DEG360_Q);
    localparam logic signed [ACC_W-1:0] DRV_MAX_A = ACC_W'(DRIVE_MAX_Q);
    localparam logic signed [ACC_W-1:0] DRV_MIN_A = -(ACC_W'(DRIVE_MIN_M));

    // Captured samples
    logic [SAMPLE_W-1:0] pos_smp_reg, spd_smp_reg, knob_smp_reg;

    // Working registers
    logic signed [POS_W-1:0]  pos_reg, pos_next;
    logic signed [SPD_W-1:0]  spd_reg, spd_next;
    logic signed [POS_W-1:0]  sp_reg, sp_next;
    logic signed [POS_W-1:0]  e_reg, e_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DRV_W-1:0]  drive_reg, drive_next;
    logic [Z_W-1:0]           z_reg, z_next;
    logic [DUTY_W-1:0]        duty_reg, duty_next;

    // Result register and loop state
    logic [DUTY_W-1:0]        out_duty_reg;
    logic signed [DRV_W-1:0]  out_drive_reg;
    logic signed [DRV_W-1:0]  prev_drive_reg;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [POS_W-1:0]  prev_pos_reg;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;

    logic signed [POS_W:0]    pos_diff;
    logic signed [POS_W:0]    e_full;
    logic signed [POS_W-1:0]  user_pos_q;
    logic signed [POS_W-1:0]  user_spd_q;
    logic signed [POS_W-1:0]  setpoint;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [PROD_W-1:0] prod_shr;
    logic signed [ERR_W-1:0]  spd_ext;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [ACC_W-1:0]  acc_shr;
    logic signed [T_W:0]      t_s;
    logic [T_W-1:0]           t_u;
    logic [T_W+FRAC_SH-1:0]   t_scaled;
    logic [Q_W-1:0]           q_est;
    logic [Q_W-1:0]           q_fix;
    logic [R_W-1:0]           q_prod;
    logic [R_W-1:0]           rem;

    assign pwm_duty    = out_duty_reg;
    assign drive_level = out_drive_reg;

    // Setpoints in Q10.10; the user position is negated
    assign user_pos_q = -{{(POS_W - UPOS_W - FRAC_SH){cfg.user_position[UPOS_W-1]}},
                          cfg.user_position, {FRAC_SH{1'b0}}};
    assign user_spd_q = {{(POS_W - USPD_W - FRAC_SH){cfg.user_speed[USPD_W-1]}},
                         cfg.user_speed, {FRAC_SH{1'b0}}};

    always_comb
    begin
        if (!cfg.control_mode)
        begin
            setpoint = cfg.setpoint_from_user ? user_pos_q : scale_angle(knob_smp_reg);
        end
        else if (cfg.setpoint_from_user)
        begin
            setpoint = user_spd_q;
        end
        else
        begin
            setpoint = POS_W'(scale_speed(knob_smp_reg));
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        unique case (ctl.mul_sel)
            MUL_GAIN_E:
            begin
                mul_a = MA_W'(cfg.position_gain);
                mul_b = MB_W'(e_reg);
            end
            MUL_A1_PD:
            begin
                mul_a = MA_W'(cfg.speed_a1);
                mul_b = MB_W'(prev_drive_reg);
            end
            MUL_B0_ERR:
            begin
                mul_a = MA_W'(cfg.speed_b0);
                mul_b = err_reg;
            end
            MUL_B1_PE:
            begin
                mul_a = MA_W'(cfg.speed_b1);
                mul_b = prev_err_reg;
            end
            MUL_RECIP:
            begin
                mul_a = MA_W'(RECIP_M);
                mul_b = $signed({{(MB_W - Z_W){1'b0}}, z_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ALU
    always_comb
    begin
        pos_diff = (POS_W + 1)'(pos_reg) - (POS_W + 1)'(prev_pos_reg);
        e_full   = (POS_W + 1)'(sp_reg) - (POS_W + 1)'(pos_reg);
        prod_rnd = prod_reg + PROD_W'(RND_HALF);
        prod_shr = prod_rnd >>> RND_SH;
        spd_ext  = ERR_W'(spd_reg);
        acc_rnd  = acc_reg + ACC_W'(RND_HALF);
        acc_shr  = acc_rnd >>> RND_SH;
        t_s      = (T_W + 1)'(drive_reg) * (T_W + 1)'(DUTY_VSCALE)
                   + (T_W + 1)'(DUTY_OFFSET);
        t_u      = t_s[T_W-1:0];
        t_scaled = {t_u, {FRAC_SH{1'b0}}} - (T_W + FRAC_SH)'(t_u);
        q_est    = prod_reg[RECIP_SH+Q_W-1:RECIP_SH];
        q_prod   = R_W'(q_est) * R_W'(DUTY_DIV);
        rem      = R_W'(z_reg) - q_prod;
        q_fix    = (rem >= R_W'(DUTY_DIV)) ? q_est + Q_W'(1) : q_est;

        pos_next   = pos_reg;
        spd_next   = spd_reg;
        sp_next    = sp_reg;
        e_next     = e_reg;
        err_next   = err_reg;
        drive_next = drive_reg;
        z_next     = z_reg;
        duty_next  = duty_reg;

        unique case (ctl.alu_op)
            ALU_NOP: ;
            ALU_SCALE:
            begin
                pos_next = scale_angle(pos_smp_reg);
                spd_next = scale_speed(spd_smp_reg);
                sp_next  = setpoint;
            end
            ALU_UNWRAP_LO:
            begin
                if (pos_diff < -DEG180_X)
                begin
                    pos_next = pos_reg + DEG360_P;
                end
            end
            ALU_UNWRAP_HI:
            begin
                if (pos_diff > DEG180_X)
                begin
                    pos_next = pos_reg - DEG360_P;
                end
            end
            ALU_EDIFF:     e_next = e_full[POS_W-1:0];
            ALU_WRAP_LO:
            begin
                if (e_reg < -DEG180_P)
                begin
                    e_next = e_reg + DEG360_P;
                end
            end
            ALU_WRAP_HI:
            begin
                if (e_reg > DEG180_P)
                begin
                    e_next = e_reg - DEG360_P;
                end
            end
            ALU_ERR_POS:   err_next = ERR_W'(prod_shr) - spd_ext;
            ALU_ERR_SPD:   err_next = ERR_W'(sp_reg) - spd_ext;
            ALU_DRIVE:
            begin
                if (acc_shr > DRV_MAX_A)
                begin
                    drive_next = DRIVE_MAX_D;
                end
                else if (acc_shr < DRV_MIN_A)
                begin
                    drive_next = DRIVE_MIN_D;
                end
                else
                begin
                    drive_next = DRV_W'(acc_shr);
                end
            end
            // floor(t * 1023 / 1024), then divided by 269 through the multiplier
            ALU_DUTY_PREP: z_next = t_scaled[T_W+FRAC_SH-1:FRAC_SH];
            ALU_DUTY:
            begin
                duty_next = (q_fix > Q_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                     : q_fix[DUTY_W-1:0];
            end
            default: ;
        endcase

        prod_ext = ACC_W'(prod_reg);
        unique case (ctl.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            pos_smp_reg  <= position_sample;
            spd_smp_reg  <= speed_sample;
            knob_smp_reg <= knob_sample;
        end
        if (ctl.mul_sel != MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctl.commit)
        begin
            out_duty_reg  <= duty_reg;
            out_drive_reg <= drive_reg;
        end
        pos_reg   <= pos_next;
        spd_reg   <= spd_next;
        sp_reg    <= sp_next;
        e_reg     <= e_next;
        err_reg   <= err_next;
        acc_reg   <= acc_next;
        drive_reg <= drive_next;
        z_reg     <= z_next;
        duty_reg  <= duty_next;
    end

    // Loop state, updated as the result is committed to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_drive_reg <= '0;
            prev_err_reg   <= '0;
            prev_pos_reg   <= '0;
        end
        else if (ctl.commit)
        begin
            prev_drive_reg <= drive_reg;
            prev_err_reg   <= err_reg;
            prev_pos_reg   <= pos_reg;
        end
    end

endmodule

/* design/cascaded_position_speed_servo.sv */
// Top level of the cascaded position and speed servo controller.
// One transfer on sample_ch carries a control tick (angle, tachometer and knob
// samples); the block answers with exactly one transfer on result_ch holding the
// PWM duty and the saturated drive voltage in Q10.10 volts. Work is done by a
// microcoded sequencer stepping one shared 17x25 multiplier and a small ALU
// along a program path that is shorter in speed mode than in position mode; a
// new tick is taken only in the wait step, once the last one is through. The
// multiplier is used five times in position mode and four in speed mode (the
// last use is the duty division), one control word each. A finished result
// sits in its own output register, so the next tick can be taken while it waits;
// the block only holds in its last step when a second result would overwrite an
// untaken one. Configuration is written through cfg_we / cfg_index / cfg_data,
// index as listed (control mode, setpoint source, user position, user speed,
// outer gain, a1, b0, b1), and should be changed only while no tick is in flight.
// Loop state (previous drive, error and angle) clears on reset.
module cascaded_position_speed_servo (
    input  logic                              clk,
    input  logic                              rst_n,
    cpss_in_if.sink                           sample_ch,
    cpss_out_if.source                        result_ch,
    input  logic                              cfg_we,
    input  logic [cpss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpss_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cpss_pkg::*;

    cfg_t cfg_reg, cfg_next;
    ctl_t ctl;

    // Register file: field widths are taken from the low data bits
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CONTROL_MODE:  cfg_next.control_mode       = cfg_data[0];
                REG_SETPOINT_USER: cfg_next.setpoint_from_user = cfg_data[0];
                REG_USER_POSITION: cfg_next.user_position      = cfg_data[UPOS_W-1:0];
                REG_USER_SPEED:    cfg_next.user_speed         = cfg_data[USPD_W-1:0];
                REG_POSITION_GAIN: cfg_next.position_gain      = cfg_data[GAIN_W-1:0];
                REG_SPEED_A1:      cfg_next.speed_a1           = cfg_data[GAIN_W-1:0];
                REG_SPEED_B0:      cfg_next.speed_b0           = cfg_data[GAIN_W-1:0];
                REG_SPEED_B1:      cfg_next.speed_b1           = cfg_data[GAIN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: owns the handshakes and the step counter
    cpss_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .speed_mode (cfg_reg.control_mode),
        .in_valid   (sample_ch.valid),
        .in_ready   (sample_ch.ready),
        .out_valid  (result_ch.valid),
        .out_ready  (result_ch.ready),
        .ctl        (ctl)
    );

    // Datapath: scaling, unwrap/wrap, gain, incremental law, clamp, duty
    cpss_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .cfg             (cfg_reg),
        .position_sample (sample_ch.position_sample),
        .speed_sample    (sample_ch.speed_sample),
        .knob_sample     (sample_ch.knob_sample),
        .pwm_duty        (result_ch.pwm_duty),
        .drive_level     (result_ch.drive_level)
    );

endmodule

/* design/cpss_chk.sv */
// Port-level checks of the servo controller and their binding to the top level.
module cpss_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              sample_valid,
    input logic                              sample_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [cpss_pkg::DUTY_W-1:0]       pwm_duty,
    input logic signed [cpss_pkg::DRV_W-1:0] drive_level
);
    import cpss_pkg::*;

    // One tick at a time: no transfer straight after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("sample taken in back-to-back cycles");

    // A new result is never raised from the wait step
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!sample_ready))
        else $error("result raised from the wait step");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (drive_level >= DRIVE_MIN_D && drive_level <= DRIVE_MAX_D))
        else $error("drive level outside saturation limits");

    // Duty sits at zero when the drive is on its negative limit
    a_duty_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && drive_level == DRIVE_MIN_D) |-> pwm_duty == '0)
        else $error("duty not zero at negative drive limit");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(pwm_duty) && $stable(drive_level)))
        else $error("stalled result changed");

endmodule

bind cascaded_position_speed_servo cpss_chk u_cpss_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_ch.valid),
    .sample_ready (sample_ch.ready),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .pwm_duty     (result_ch.pwm_duty),
    .drive_level  (result_ch.drive_level)
);

/* sim/cascaded_position_speed_servo_tb.sv */
// Self-checking testbench of the cascaded position and speed servo controller.
`timescale 1ns / 1ps

import cpss_pkg::*;

// Predicts the duty and drive of every control tick and checks the results in order.
class servo_drive_checker;
    typedef struct {
        logic [DUTY_W-1:0]       duty;
        logic signed [DRV_W-1:0] drive;
    } drive_t;

    localparam longint DUTY_SPAN = 275456;  // 26.9 V in Q10.10, times ten

    cfg_t        regs;
    longint      last_drive;
    longint      last_error;
    longint      last_angle;
    drive_t      pending_drives[$];
    int unsigned mismatches;

    function new();
        regs         = CFG_RESET;
        last_drive   = 0;
        last_error   = 0;
        last_angle   = 0;
        mismatches   = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CONTROL_MODE:  regs.control_mode       = data[0];
            REG_SETPOINT_USER: regs.setpoint_from_user = data[0];
            REG_USER_POSITION: regs.user_position      = data[UPOS_W-1:0];
            REG_USER_SPEED:    regs.user_speed         = data[USPD_W-1:0];
            REG_POSITION_GAIN: regs.position_gain      = data;
            REG_SPEED_A1:      regs.speed_a1           = data;
            REG_SPEED_B0:      regs.speed_b0           = data;
            REG_SPEED_B1:      regs.speed_b1           = data;
            default: ;
        endcase
    endfunction

    // adc * 360 / 1023 - 180 deg, rounded half up, Q10.10
    function longint angle_q(input logic [SAMPLE_W-1:0] a);
        return (longint'(a) * DEG360_Q + 511) / 1023 - DEG180_Q;
    endfunction

    function longint speed_q(input logic [SAMPLE_W-1:0] a);
        return (longint'(a) * 102400 + 511) / 1023 - SPD50_Q;
    endfunction

    // Q4.12 x Q10.10 product back to Q10.10, half up
    function longint rnd12(input longint x);
        return (x + 64'sd2048) >>> 12;
    endfunction

    // one step of +-360 deg towards anchor, low side checked first
    function longint fold(input longint x, input longint anchor);
        if (x - anchor < -DEG180_Q)
            x += DEG360_Q;
        if (x - anchor > DEG180_Q)
            x -= DEG360_Q;
        return x;
    endfunction

    function void note_tick(input logic [SAMPLE_W-1:0] p, input logic [SAMPLE_W-1:0] s,
                            input logic [SAMPLE_W-1:0] k);
        longint ang;
        longint spd;
        longint perr;
        longint err;
        longint drv;
        longint duty;
        ang = angle_q(p);
        spd = speed_q(s);
        if (regs.control_mode == 1'b0) begin
            ang = fold(ang, last_angle);
            if (regs.setpoint_from_user)
                perr = -longint'(regs.user_position) * 1024 - ang;
            else
                perr = angle_q(k) - ang;
            perr = fold(perr, 0);
            err  = rnd12(longint'(regs.position_gain) * perr) - spd;
        end
        else if (regs.setpoint_from_user)
            err = longint'(regs.user_speed) * 1024 - spd;
        else
            err = speed_q(k) - spd;

        drv = rnd12(longint'(regs.speed_a1) * last_drive + longint'(regs.speed_b0) * err
                    - longint'(regs.speed_b1) * last_error);
        if (drv > DRIVE_MAX_Q)
            drv = DRIVE_MAX_Q;
        if (drv < -DRIVE_MIN_M)
            drv = -DRIVE_MIN_M;

        duty = ((drv * DUTY_VSCALE + DUTY_OFFSET) * DUTY_MAX) / DUTY_SPAN;
        if (duty < 0)
            duty = 0;
        if (duty > DUTY_MAX)
            duty = DUTY_MAX;

        last_drive = drv;
        last_error = err;
        last_angle = ang;
        pending_drives.push_back('{duty: DUTY_W'(duty), drive: DRV_W'(drv)});
    endfunction

    function void check_drive(input logic [DUTY_W-1:0] duty,
                              input logic signed [DRV_W-1:0] drive);
        drive_t want;
        if (pending_drives.size() == 0) begin
            $error("result with no tick outstanding: pwm_duty %0d, drive_level %0d",
                   duty, drive);
            mismatches++;
            return;
        end
        want = pending_drives.pop_front();
        if (duty !== want.duty) begin
            $error("pwm_duty: expected %0d, actual %0d", want.duty, duty);
            mismatches++;
        end
        if (drive !== want.drive) begin
            $error("drive_level: expected %0d, actual %0d", want.drive, drive);
            mismatches++;
        end
    endfunction

    function int pending();
        return pending_drives.size();
    endfunction
endclass

module cascaded_position_speed_servo_tb;

    // Run shape
    localparam int RANDOM_PHASES   = 12;
    localparam int TICKS_PER_PHASE = 100;
    localparam int LONG_HOLD       = 400;   // result side held off, in cycles
    localparam int SETTLE_CYCLES   = 40;    // comfortably over the longest tick

    // Nominal loop coefficients, Q4.12
    localparam int GAIN_NOM = 2458;
    localparam int A1_NOM   = 4096;
    localparam int B0_NOM   = 304;
    localparam int B1_NOM   = 270;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cpss_in_if  sample_ch ();
    cpss_out_if result_ch ();

    cascaded_position_speed_servo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    servo_drive_checker sb = new();

    bit                  hold_off_request = 1'b0;
    int                  burst_left       = 0;
    logic [SAMPLE_W-1:0] last_position_sample = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sample side. Ticks go out in bursts of random length; between
    // bursts the valid line drops for a random gap, and about a quarter
    // of the bursts follow on with no gap at all. The tick is handed to
    // the predictor at the very edge of its transfer, in this process, so
    // the drain check below never races the bookkeeping.
    // ------------------------------------------------------------------
    task automatic offer(input logic [SAMPLE_W-1:0] p, input logic [SAMPLE_W-1:0] s,
                         input logic [SAMPLE_W-1:0] k);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.position_sample <= p;
        sample_ch.speed_sample    <= s;
        sample_ch.knob_sample     <= k;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        sb.note_tick(p, s, k);
        burst_left--;
        last_position_sample = p;
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One register write per edge; the caller drops cfg_we after the last.
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] mode,
                               input logic [CFG_DATA_W-1:0] src,
                               input logic [CFG_DATA_W-1:0] upos,
                               input logic [CFG_DATA_W-1:0] uspd,
                               input logic [CFG_DATA_W-1:0] gain,
                               input logic [CFG_DATA_W-1:0] a1,
                               input logic [CFG_DATA_W-1:0] b0,
                               input logic [CFG_DATA_W-1:0] b1);
        program_reg(REG_CONTROL_MODE,  mode);
        program_reg(REG_SETPOINT_USER, src);
        program_reg(REG_USER_POSITION, upos);
        program_reg(REG_USER_SPEED,    uspd);
        program_reg(REG_POSITION_GAIN, gain);
        program_reg(REG_SPEED_A1,      a1);
        program_reg(REG_SPEED_B0,      b0);
        program_reg(REG_SPEED_B1,      b1);
        cfg_we <= 1'b0;
    endtask

    // Coefficients: nominal early on, both extremes in the last two phases,
    // otherwise a spread of extremes, zero, raw bits and values near nominal.
    function automatic logic [CFG_DATA_W-1:0] phase_coeff(input int ph, input int nominal);
        if (ph == RANDOM_PHASES - 1)
            return 16'h7FFF;
        if (ph == RANDOM_PHASES - 2)
            return 16'h8000;
        if (ph < 4)
            return CFG_DATA_W'(nominal);
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return '0;
            3:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'(nominal - nominal / 4
                                        + int'($urandom_range(0, nominal / 2)));
        endcase
    endfunction

    // User setpoints: limits, in-range values, and now and then raw bits
    // beyond the nominal range (the block keeps only its own width).
    function automatic logic [CFG_DATA_W-1:0] pick_setpoint(input int span);
        case ($urandom_range(0, 5))
            0:       return CFG_DATA_W'(-span);
            1:       return CFG_DATA_W'(span);
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'(int'($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mostly a slowly moving shaft, so the unwrap sees realistic sequences
    // including crossings of the converter's end stops; the rest is jumps.
    function automatic logic [SAMPLE_W-1:0] pick_position();
        if ($urandom_range(0, 3) == 0)
            return pick_sample();
        return SAMPLE_W'(int'(last_position_sample) + int'($urandom_range(0, 120)) - 60);
    endfunction

    // ------------------------------------------------------------------
    // Result side. The ready pattern switches periodically between
    // always ready, coin toss, one cycle in four and a square wave. On
    // request it holds off for a long stretch so the block backs up and
    // stops taking ticks.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int cyc;
        int style;
        cyc   = 0;
        style = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else begin
                if (cyc % 64 == 0)
                    style = $urandom_range(0, 3);
                case (style)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom);
                    2:       result_ch.ready <= (cyc % 4 == 0);
                    default: result_ch.ready <= ((cyc / 3) % 2 == 0);
                endcase
                cyc++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_drive(result_ch.pwm_duty, result_ch.drive_level);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= REG_CONTROL_MODE;
        cfg_data                  <= '0;
        sample_ch.valid           <= 1'b0;
        sample_ch.position_sample <= '0;
        sample_ch.speed_sample    <= '0;
        sample_ch.knob_sample     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: position control from the knob, nominal gains.
        offer('0, '0, '0);          // all minima, angle sits exactly on -180
        offer('1, '1, '1);          // all maxima, forward jump unwrapped
        offer(10'd512, 10'd511, 10'd512);
        offer(10'd100, 10'd512, '1);  // raw jump of under half a turn, unwrapped against the stored angle
        offer(10'd900, '0, 10'd100);
        offer(10'd512, 10'd512, '0);  // knob far below, error stays just inside half a turn
        offer('1, 10'd512, 10'd512);
        offer('0, '1, '1);          // knob far above, error wraps down
        settle();

        // User position setpoint at both limits (it is negated before use).
        load_config(0, 1, -180, 0, GAIN_NOM, A1_NOM, B0_NOM, B1_NOM);
        offer(10'd512, 10'd512, '0);
        offer('0, 10'd300, '1);
        settle();
        load_config(0, 1, 180, 0, GAIN_NOM, A1_NOM, B0_NOM, B1_NOM);
        offer(10'd700, 10'd512, 10'd512);
        offer('1, 10'd800, '0);
        settle();

        // Speed control from the knob; angle taken raw.
        load_config(1, 0, 0, 0, GAIN_NOM, A1_NOM, B0_NOM, B1_NOM);
        offer(10'd512, '0, '1);
        offer('0, '1, '0);
        offer('1, 10'd512, 10'd512);
        settle();

        // Speed control from the user register at both limits.
        load_config(1, 1, 0, -50, GAIN_NOM, A1_NOM, B0_NOM, B1_NOM);
        offer('0, '1, '0);
        settle();
        load_config(1, 1, 0, 50, GAIN_NOM, A1_NOM, B0_NOM, B1_NOM);
        offer('1, '0, '1);
        settle();

        // Heavy error weight, no memory: drive pinned at each rail.
        load_config(1, 0, 0, 0, GAIN_NOM, 0, 16'h7FFF, 0);
        offer('0, '0, '1);
        offer('0, '1, '0);

        // Random phases. Mode and setpoint source follow the phase number so
        // every combination is run; upper data bits are random noise.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            load_config({15'($urandom), 1'(ph)}, {15'($urandom), 1'(ph >> 1)},
                        pick_setpoint(180), pick_setpoint(50),
                        phase_coeff(ph, GAIN_NOM), phase_coeff(ph, A1_NOM),
                        phase_coeff(ph, B0_NOM), phase_coeff(ph, B1_NOM));
            if (ph == 5)
                hold_off_request = 1'b1;   // ticks keep coming while results back up
            repeat (TICKS_PER_PHASE)
                offer(pick_position(), pick_sample(), pick_sample());
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: well over ten times a slow correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
design/cpss_pkg.sv
design/cpss_if.sv
design/cpss_seq.sv
design/cpss_dp.sv
design/cascaded_position_speed_servo.sv
design/cpss_chk.sv
sim/cascaded_position_speed_servo_tb.sv
